>>> hdl/ezrd_pkg.sv
// Package: shared widths, phase and result-kind codes for the escape zero-run decoder
`timescale 1ns / 1ps

package ezrd_pkg;

    // fixed field widths
    localparam int unsigned ByteW   = 8;
    localparam int unsigned KindW   = 2;
    localparam int unsigned RepeatW = 16;
    localparam int unsigned TotalW  = 24;
    localparam int unsigned CapW    = 24;
    localparam int unsigned HighW   = 7;

    // default width of the per-stream byte counter
    localparam int unsigned OutCountWidthDef = 24;

    // configuration bus
    localparam int unsigned ApbDataW = 32;
    localparam int unsigned ApbAddrW = 3;

    // register reset values
    localparam logic [CapW-1:0] CapReset = '1;

    // result kinds
    typedef enum logic [KindW-1:0] {
        KIND_RUN   = 2'd0,
        KIND_END   = 2'd1,
        KIND_OVF   = 2'd2,
        KIND_TRUNC = 2'd3
    } t_kind;

    // register indexes
    localparam logic REG_OUT_CAPACITY = 1'b0;

    // decoder phase, one-hot
    typedef enum logic [4:0] {
        PH_ESC  = 5'b00001,
        PH_DATA = 5'b00010,
        PH_CODE = 5'b00100,
        PH_LOW  = 5'b01000,
        PH_DROP = 5'b10000
    } t_phase;

    // code bytes after an escape
    localparam logic [ByteW-1:0] CODE_END     = 8'h00;
    localparam logic [ByteW-1:0] CODE_ESCAPE  = 8'h01;
    localparam logic [RepeatW-1:0] LongBias   = 16'h0080;

endpackage

>>> hdl/ezrd_in_if.sv
// Interface: input channel carrying one compressed byte per word
`timescale 1ns / 1ps

interface ezrd_in_if;
    logic                        valid;
    logic                        ready;
    logic [ezrd_pkg::ByteW-1:0]  in_byte;
    logic                        last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

>>> hdl/ezrd_out_if.sv
// Interface: result channel carrying one decoded run or stream event per word
`timescale 1ns / 1ps

interface ezrd_out_if;
    logic                          valid;
    logic                          ready;
    logic [ezrd_pkg::KindW-1:0]    kind;
    logic [ezrd_pkg::ByteW-1:0]    out_value;
    logic [ezrd_pkg::RepeatW-1:0]  repeat_count;
    logic [ezrd_pkg::TotalW-1:0]   total_written;

    modport source (output valid, output kind, output out_value, output repeat_count,
                    output total_written, input ready);
    modport sink   (input valid, input kind, input out_value, input repeat_count,
                    input total_written, output ready);
endinterface

>>> hdl/escape_zero_run_decoder.sv
// Top level: escape-code zero-run decoder with APB capacity register
//
//  port      | dir | word                                         | handshake
//  ----------+-----+----------------------------------------------+-------------
//  i_in      | in  | in_byte, last_in                             | valid/ready
//  o_out     | out | kind, out_value, repeat_count, total_written | valid/ready
//  APB       | in  | out_capacity at byte address 0               | pready tied
//
//  One input word per cycle. A word is decoded in the cycle it is accepted and
//  its result, if any, sits in the output register from the next cycle.
//  Input ready is high while the output register is empty or being drained, so
//  the output register alone sets the rate under back-pressure.
//  Synchronous active-low reset: phase returns to awaiting the escape byte,
//  counters clear, out_capacity returns to all ones.
`timescale 1ns / 1ps

module escape_zero_run_decoder #(
    parameter int unsigned OUT_COUNT_WIDTH = ezrd_pkg::OutCountWidthDef
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ezrd_in_if.sink                           i_in,
    ezrd_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ezrd_pkg::ApbAddrW-1:0]     paddr,
    input  logic [ezrd_pkg::ApbDataW-1:0]     pwdata,
    output logic [ezrd_pkg::ApbDataW-1:0]     prdata,
    output logic                              pready
);

    localparam int unsigned W  = OUT_COUNT_WIDTH;
    // sum width: holds counter + longest run and the capacity, plus a carry
    localparam int unsigned SW = ((W > ezrd_pkg::CapW) ? W : ezrd_pkg::CapW) + 1;

    // state
    ezrd_pkg::t_phase               r_phase, n_phase;
    logic [ezrd_pkg::ByteW-1:0]     r_esc, n_esc;
    logic [ezrd_pkg::HighW-1:0]     r_high, n_high;
    logic [W-1:0]                   r_bw, n_bw;
    logic [ezrd_pkg::CapW-1:0]      r_cap;

    // output register
    logic                           r_out_valid;
    ezrd_pkg::t_kind                r_kind, n_kind;
    logic [ezrd_pkg::ByteW-1:0]     r_value, n_value;
    logic [ezrd_pkg::RepeatW-1:0]   r_count, n_count;
    logic [ezrd_pkg::TotalW-1:0]    r_total, n_total;
    logic                           n_res;

    logic                           in_acc;
    logic                           cfg_wr;
    logic                           last;
    logic [ezrd_pkg::ByteW-1:0]     b;

    // run evaluation
    logic                           run_req;
    logic [ezrd_pkg::ByteW-1:0]     run_value;
    logic [ezrd_pkg::RepeatW-1:0]   run_count;
    logic [SW-1:0]                  run_sum;
    logic [SW-1:0]                  bw_ext;
    logic                           run_ovf;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign last       = i_in.last_in;
    assign b          = i_in.in_byte;

    // APB: single register, writes complete in the access cycle
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ezrd_pkg::REG_OUT_CAPACITY);
    always_comb begin
        if (paddr[2] == ezrd_pkg::REG_OUT_CAPACITY) begin
            prdata = ezrd_pkg::ApbDataW'(r_cap);
        end else begin
            prdata = '0;
        end
    end

    // overflow check on the candidate run
    assign bw_ext  = SW'(r_bw);
    assign run_sum = bw_ext + SW'(run_count);
    assign run_ovf = (run_sum > SW'(r_cap)) || (run_sum[SW-1:W] != '0);

    // decode of one byte
    always_comb begin
        n_phase   = r_phase;
        n_esc     = r_esc;
        n_high    = r_high;
        n_bw      = r_bw;
        n_res     = 1'b0;
        n_kind    = ezrd_pkg::KIND_RUN;
        n_value   = '0;
        n_count   = '0;
        n_total   = bw_ext[ezrd_pkg::TotalW-1:0];
        run_req   = 1'b0;
        run_value = '0;
        run_count = '0;

        unique case (r_phase)
            ezrd_pkg::PH_ESC: begin
                n_esc = b;
                n_bw  = '0;
                if (last) begin
                    n_res   = 1'b1;
                    n_kind  = ezrd_pkg::KIND_TRUNC;
                    n_total = '0;
                end else begin
                    n_phase = ezrd_pkg::PH_DATA;
                end
            end
            ezrd_pkg::PH_DATA: begin
                if (b != r_esc) begin
                    run_req   = 1'b1;
                    run_value = b;
                    run_count = ezrd_pkg::RepeatW'(1);
                end else if (last) begin
                    n_res  = 1'b1;
                    n_kind = ezrd_pkg::KIND_TRUNC;
                    n_bw   = '0;
                    n_phase = ezrd_pkg::PH_ESC;
                end else begin
                    n_phase = ezrd_pkg::PH_CODE;
                end
            end
            ezrd_pkg::PH_CODE: begin
                if (b == ezrd_pkg::CODE_END) begin
                    n_res   = 1'b1;
                    n_kind  = ezrd_pkg::KIND_END;
                    n_bw    = '0;
                    n_phase = ezrd_pkg::PH_ESC;
                end else if (b == ezrd_pkg::CODE_ESCAPE) begin
                    run_req   = 1'b1;
                    run_value = r_esc;
                    run_count = ezrd_pkg::RepeatW'(1);
                end else if (!b[7]) begin
                    run_req   = 1'b1;
                    run_count = ezrd_pkg::RepeatW'(b);
                end else begin
                    n_high = b[ezrd_pkg::HighW-1:0];
                    if (last) begin
                        n_res   = 1'b1;
                        n_kind  = ezrd_pkg::KIND_TRUNC;
                        n_bw    = '0;
                        n_phase = ezrd_pkg::PH_ESC;
                    end else begin
                        n_phase = ezrd_pkg::PH_LOW;
                    end
                end
            end
            ezrd_pkg::PH_LOW: begin
                run_req   = 1'b1;
                run_count = {1'b0, r_high, b} + ezrd_pkg::LongBias;
            end
            ezrd_pkg::PH_DROP: begin
                if (last) begin
                    n_bw    = '0;
                    n_phase = ezrd_pkg::PH_ESC;
                end
            end
            default: begin
                n_phase = ezrd_pkg::PH_ESC;
            end
        endcase

        // run outcome: overflow wins over truncation
        if (run_req) begin
            n_res = 1'b1;
            if (run_ovf || last) begin
                n_kind  = run_ovf ? ezrd_pkg::KIND_OVF : ezrd_pkg::KIND_TRUNC;
                n_bw    = '0;
                n_phase = last ? ezrd_pkg::PH_ESC : ezrd_pkg::PH_DROP;
            end else begin
                n_kind  = ezrd_pkg::KIND_RUN;
                n_value = run_value;
                n_count = run_count;
                n_bw    = run_sum[W-1:0];
                n_total = run_sum[ezrd_pkg::TotalW-1:0];
                n_phase = ezrd_pkg::PH_DATA;
            end
        end else if (n_res && (n_kind == ezrd_pkg::KIND_TRUNC)) begin
            // truncation outside a run also drops to awaiting escape
            n_phase = ezrd_pkg::PH_ESC;
        end
    end

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ezrd_pkg::PH_ESC;
            r_esc   <= '0;
            r_high  <= '0;
            r_bw    <= '0;
            r_cap   <= ezrd_pkg::CapReset;
        end else begin
            if (in_acc) begin
                r_phase <= n_phase;
                r_esc   <= n_esc;
                r_high  <= n_high;
                r_bw    <= n_bw;
            end
            if (cfg_wr) begin
                r_cap <= pwdata[ezrd_pkg::CapW-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && n_res) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_res) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.out_value     = r_value;
    assign o_out.repeat_count  = r_count;
    assign o_out.total_written = r_total;

endmodule
